// ----- rtl/pcxrle_pkg.sv -----
`default_nettype none
package pcxrle_pkg;

   // Field widths
   localparam int COL_W      = 12;
   localparam int ROW_W      = 10;
   localparam int LEFT_W     = 11;
   localparam int BPL_W      = 11;
   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Default screen height
   localparam int SCREEN_HEIGHT_DEF = 400;

   // Register reset values
   localparam logic [BPL_W-1:0] BPL_RESET       = 11'd640;
   localparam logic [ROW_W-1:0] ROW_LIMIT_RESET = 10'd399;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_COL       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_ROW        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_LINE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LIMIT      = 2'd3;

   // Input function codes
   localparam logic FUNC_DATA  = 1'b0;
   localparam logic FUNC_BEGIN = 1'b1;

   // Marker prefix in the top two bits of a byte
   localparam logic [1:0] MARKER_PREFIX = 2'b11;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic begin_load;
      logic mark_done;
      logic set_run;
      logic zero_run;
      logic start_emit;
      logic emit_pixel;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_begin;
      logic blocked;
      logic pending;
      logic run_zero;
      logic marker;
      logic last_pixel;
      logic slot_free;
   } stat_type;

endpackage
`default_nettype wire

// ----- rtl/pcxrle_if.sv -----
`default_nettype none
interface pcxrle_req_if;
   import pcxrle_pkg::*;
   logic              valid;
   logic              ready;
   logic              func;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface pcxrle_rsp_if;
   import pcxrle_pkg::*;
   logic              valid;
   logic              ready;
   logic [COL_W-1:0]  pixel_x;
   logic [ROW_W-1:0]  pixel_y;
   logic [BYTE_W-1:0] color_index;
   logic              last;

   modport source (output valid, output pixel_x, output pixel_y, output color_index,
                   output last, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input color_index,
                   input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/pcxrle_ctrl.sv -----
`default_nettype none
module pcxrle_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire pcxrle_pkg::stat_type stat,
   output pcxrle_pkg::cmd_type       cmd
);
   import pcxrle_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               priority if (stat.is_begin) begin
                  cmd.begin_load = 1'b1;
               end else if (stat.blocked) begin
                  cmd.mark_done = 1'b1;
               end else if (stat.pending && stat.run_zero) begin
                  cmd.zero_run = 1'b1;
               end else if (!stat.pending && stat.marker) begin
                  cmd.set_run = 1'b1;
               end else begin
                  cmd.start_emit = 1'b1;
                  state_in       = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            // Advance one pixel whenever the output slot frees up
            if (stat.slot_free) begin
               cmd.emit_pixel = 1'b1;
               if (stat.last_pixel) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/pcxrle_dp.sv -----
`default_nettype none
module pcxrle_dp #(
   parameter int SCREEN_HEIGHT = pcxrle_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wen,
   input  wire logic [pcxrle_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pcxrle_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                                  req_func,
   input  wire logic [pcxrle_pkg::BYTE_W-1:0]         req_data_byte,
   input  wire pcxrle_pkg::cmd_type                   cmd,
   output pcxrle_pkg::stat_type                       stat,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output logic [pcxrle_pkg::COL_W-1:0]               rsp_pixel_x,
   output logic [pcxrle_pkg::ROW_W-1:0]               rsp_pixel_y,
   output logic [pcxrle_pkg::BYTE_W-1:0]              rsp_color_index,
   output logic                                       rsp_last
);
   import pcxrle_pkg::*;

   localparam logic [ROW_W-1:0] ROW_CAP = ROW_W'(SCREEN_HEIGHT - 1);
   localparam logic [COL_W-1:0] COL_MAX = '1;

   // Configuration registers
   logic [LEFT_W-1:0] left_col_ff;
   logic [ROW_W-1:0]  top_row_ff;
   logic [BPL_W-1:0]  bpl_ff;
   logic [ROW_W-1:0]  row_limit_ff;

   // Decode state
   logic [COL_W-1:0]   column_ff, column_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               pending_ff, pending_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               done_ff, done_in;
   logic [BYTE_W-1:0]  color_ff, color_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]  rsp_x_ff;
   logic [ROW_W-1:0]  rsp_y_ff;
   logic [BYTE_W-1:0] rsp_color_ff;
   logic              rsp_last_ff;

   logic [ROW_W-1:0] end_row;
   logic [COL_W-1:0] line_end;
   logic [COL_W-1:0] col_next;
   logic [ROW_W-1:0] row_inc;
   logic             slot_free;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         left_col_ff  <= '0;
         top_row_ff   <= '0;
         bpl_ff       <= BPL_RESET;
         row_limit_ff <= ROW_LIMIT_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_LEFT_COL:       left_col_ff  <= csr_wdata[LEFT_W-1:0];
            CSR_TOP_ROW:        top_row_ff   <= csr_wdata[ROW_W-1:0];
            CSR_BYTES_PER_LINE: bpl_ff       <= csr_wdata[BPL_W-1:0];
            CSR_ROW_LIMIT:      row_limit_ff <= csr_wdata[ROW_W-1:0];
            default:            left_col_ff  <= left_col_ff;
         endcase
      end
   end

   // Position helpers
   assign end_row   = (row_limit_ff <= ROW_CAP) ? row_limit_ff : ROW_CAP;
   assign line_end  = COL_W'({1'b0, left_col_ff}) + COL_W'({1'b0, bpl_ff});
   assign col_next  = (column_ff < COL_MAX) ? column_ff + 1'b1 : column_ff;
   assign row_inc   = row_ff + 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Status to the controller
   always_comb begin
      stat.is_begin   = (req_func == FUNC_BEGIN);
      stat.blocked    = done_ff || (row_ff >= end_row);
      stat.pending    = pending_ff;
      stat.run_zero   = (count_ff == '0);
      stat.marker     = (req_data_byte[BYTE_W-1:BYTE_W-2] == MARKER_PREFIX);
      stat.last_pixel = (remain_ff == COUNT_W'(1));
      stat.slot_free  = slot_free;
   end

   // Next decode state
   always_comb begin
      column_in    = column_ff;
      row_in       = row_ff;
      pending_in   = pending_ff;
      count_in     = count_ff;
      done_in      = done_ff;
      color_in     = color_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.begin_load) begin
         column_in  = COL_W'({1'b0, left_col_ff});
         row_in     = top_row_ff;
         pending_in = 1'b0;
         count_in   = '0;
         done_in    = (top_row_ff >= end_row);
      end
      if (cmd.mark_done) begin
         done_in = 1'b1;
      end
      if (cmd.set_run) begin
         pending_in = 1'b1;
         count_in   = req_data_byte[COUNT_W-1:0];
      end
      // Empty run: drop it, then check the line end only for a nonzero width
      if (cmd.zero_run) begin
         pending_in = 1'b0;
         count_in   = '0;
         if ((bpl_ff != '0) && (column_ff >= line_end)) begin
            column_in = COL_W'({1'b0, left_col_ff});
            row_in    = row_inc;
            done_in   = done_ff || (row_inc >= end_row);
         end
      end
      if (cmd.start_emit) begin
         color_in   = req_data_byte;
         remain_in  = pending_ff ? count_ff : COUNT_W'(1);
         pending_in = 1'b0;
         count_in   = '0;
      end
      // Plot one pixel; on the final one wrap the line if it is full
      if (cmd.emit_pixel) begin
         rsp_valid_in = 1'b1;
         column_in    = col_next;
         remain_in    = remain_ff - 1'b1;
         if ((remain_ff == COUNT_W'(1)) && (col_next >= line_end)) begin
            column_in = COL_W'({1'b0, left_col_ff});
            row_in    = row_inc;
            done_in   = done_ff || (row_inc >= end_row);
         end
      end
   end

   // Decode state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_ff       <= '0;
         pending_ff   <= 1'b0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         column_ff    <= column_in;
         row_ff       <= row_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Color and output payload
   always_ff @(posedge clock) begin
      color_ff <= color_in;
      if (cmd.emit_pixel) begin
         rsp_x_ff     <= column_ff;
         rsp_y_ff     <= row_ff;
         rsp_color_ff <= color_ff;
         rsp_last_ff  <= (remain_ff == COUNT_W'(1));
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_color_index = rsp_color_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTH
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_pixel |-> slot_free)
      else $error("pixel emitted into an occupied output slot");
   a_start_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.start_emit |=> (remain_ff != '0))
      else $error("emit started with no pixels to plot");
   a_last_mark: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_pixel && (remain_ff == COUNT_W'(1))) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final pixel of a byte not marked last");
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !cmd.begin_load) |=> done_ff)
      else $error("image done cleared without a new image");
`endif

endmodule
`default_nettype wire

// ----- rtl/pcx_rle_pixel_decoder_top.sv -----
// PCX run-length pixel decoder.
// Each pixel of a taken byte passes through the color/run registers and then the
// output register, where it waits while the output is stalled.
// A literal is taken, then its pixel is emitted; a run takes the marker, then the
// data byte, then its pixels one by one; no byte is taken while pixels are emitted.
// Reset: synchronous, active high; clears position, run and done state and
// loads the register defaults.
`default_nettype none
module pcx_rle_pixel_decoder_top #(
   parameter int SCREEN_HEIGHT = pcxrle_pkg::SCREEN_HEIGHT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wen,
   input  wire logic [pcxrle_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pcxrle_pkg::CSR_DATA_W-1:0] csr_wdata,
   pcxrle_req_if.sink                             req_chan,
   pcxrle_rsp_if.source                           rsp_chan
);
   import pcxrle_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pcxrle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcxrle_dp #(
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_func        (req_chan.func),
      .req_data_byte   (req_chan.data_byte),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_pixel_x     (rsp_chan.pixel_x),
      .rsp_pixel_y     (rsp_chan.pixel_y),
      .rsp_color_index (rsp_chan.color_index),
      .rsp_last        (rsp_chan.last)
   );

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pcxrle_pkg::*;

   localparam int SCREEN_H     = SCREEN_HEIGHT_DEF;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_PRINTS   = 30;

   typedef struct packed {
      logic              func;
      logic [BYTE_W-1:0] data_byte;
   } enc_byte_type;

   typedef struct packed {
      logic [COL_W-1:0]  x;
      logic [ROW_W-1:0]  y;
      logic [BYTE_W-1:0] color;
      logic              last;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wen;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pcxrle_req_if req_bus ();
   pcxrle_rsp_if rsp_bus ();

   pcx_rle_pixel_decoder_top #(
      .SCREEN_HEIGHT (SCREEN_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // Encoded bytes waiting to be sent, and pixels still owed by the block
   enc_byte_type encoded_q[$];
   pixel_type    expected_pixels_q[$];

   // Decoder mirror: register copies and position/run state
   logic [LEFT_W-1:0]  cfg_left;
   logic [ROW_W-1:0]   cfg_top;
   logic [BPL_W-1:0]   cfg_bpl;
   logic [ROW_W-1:0]   cfg_limit;
   logic [COL_W-1:0]   pos_col;
   logic [ROW_W-1:0]   pos_row;
   logic               run_armed;
   logic [COUNT_W-1:0] run_len;
   logic               img_done;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic        req_fired = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned err_count = 0;
   int unsigned bytes_taken = 0;
   int unsigned pixels_seen = 0;
   int unsigned settings_used = 1;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int unsigned end_row();
      return (int'(cfg_limit) <= SCREEN_H - 1) ? cfg_limit : SCREEN_H - 1;
   endfunction

   // Plot one pixel at the current position; the column saturates
   function automatic void plot_pixel(logic [BYTE_W-1:0] color, logic fin);
      expected_pixels_q.push_back('{pos_col, pos_row, color, fin});
      if (pos_col != '1) pos_col = pos_col + 1'b1;
   endfunction

   // Advance the mirror by one accepted beat and queue the pixels it gives
   function automatic void decode_byte(logic func, logic [BYTE_W-1:0] b);
      int n;
      n = 0;
      if (func == FUNC_BEGIN) begin
         pos_col   = COL_W'(cfg_left);
         pos_row   = cfg_top;
         run_armed = 1'b0;
         run_len   = '0;
         img_done  = (pos_row >= end_row());
         return;
      end
      if (img_done || pos_row >= end_row()) begin
         img_done = 1'b1;
         return;
      end
      if (run_armed) begin
         for (int i = 0; i < int'(run_len); i++) begin
            plot_pixel(b, (i + 1) == int'(run_len));
            n++;
         end
         run_armed = 1'b0;
         run_len   = '0;
      end else if (b[7:6] == MARKER_PREFIX) begin
         run_armed = 1'b1;
         run_len   = b[COUNT_W-1:0];
         return;
      end else begin
         plot_pixel(b, 1'b1);
         n++;
      end
      // Line end is checked once all pixels of the byte are out
      if (n > 0 || cfg_bpl != 0) begin
         if (int'(pos_col) >= int'(cfg_left) + int'(cfg_bpl)) begin
            pos_col = COL_W'(cfg_left);
            pos_row = pos_row + 1'b1;
            if (pos_row >= end_row()) img_done = 1'b1;
         end
      end
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      err_count++;
      if (err_count <= MAX_PRINTS)
         $display("MISMATCH at pixel %0d: %s got %0d expected %0d", pixels_seen, what, got,
                  want);
   endtask

   // Drive request beats from the queue; hold a beat until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fired) begin
         if (encoded_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            enc_byte_type item;
            item = encoded_q.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.func      <= item.func;
            req_bus.data_byte <= item.data_byte;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Stall the pixel output at random
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Predict on accepted request beats, check accepted pixel beats
   always @(posedge clock) begin
      pixel_type want;
      cycle_count++;
      req_fired <= req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.func, req_bus.data_byte);
            bytes_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pixels_q.size() == 0) begin
               report_mismatch("pixel with nothing pending, x", rsp_bus.pixel_x, 0);
            end else begin
               want = expected_pixels_q.pop_front();
               if (rsp_bus.pixel_x !== want.x)
                  report_mismatch("pixel_x", rsp_bus.pixel_x, want.x);
               if (rsp_bus.pixel_y !== want.y)
                  report_mismatch("pixel_y", rsp_bus.pixel_y, want.y);
               if (rsp_bus.color_index !== want.color)
                  report_mismatch("color_index", rsp_bus.color_index, want.color);
               if (rsp_bus.last !== want.last)
                  report_mismatch("last", rsp_bus.last, want.last);
            end
            pixels_seen++;
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d pixels still pending", cycle_count,
                  expected_pixels_q.size());
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic void queue_byte(logic func, logic [BYTE_W-1:0] b);
      encoded_q.push_back('{func, b});
   endfunction

   function automatic void queue_run(logic [COUNT_W-1:0] count, logic [BYTE_W-1:0] color);
      queue_byte(FUNC_DATA, {MARKER_PREFIX, count});
      queue_byte(FUNC_DATA, color);
   endfunction

   // Mostly literals and marker/data pairs, some restarts and stray bytes
   task automatic queue_random_bytes(int unsigned count);
      int unsigned made;
      int unsigned sel;
      made = 0;
      while (made < count) begin
         sel = $urandom_range(0, 99);
         if (sel < 6) begin
            queue_byte(FUNC_BEGIN, BYTE_W'($urandom_range(0, 255)));
         end else if (sel < 50) begin
            queue_byte(FUNC_DATA, BYTE_W'($urandom_range(0, 8'hBF)));
            made++;
         end else if (sel < 92) begin
            if ($urandom_range(0, 3) == 0)
               queue_run(COUNT_W'($urandom_range(0, 63)), BYTE_W'($urandom_range(0, 255)));
            else
               queue_run(COUNT_W'($urandom_range(0, 6)), BYTE_W'($urandom_range(0, 255)));
            made += 2;
         end else begin
            queue_byte(FUNC_DATA, BYTE_W'($urandom_range(0, 255)));
            made++;
         end
      end
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      unique case (idx)
         CSR_LEFT_COL:       cfg_left  = LEFT_W'(value);
         CSR_TOP_ROW:        cfg_top   = ROW_W'(value);
         CSR_BYTES_PER_LINE: cfg_bpl   = BPL_W'(value);
         CSR_ROW_LIMIT:      cfg_limit = ROW_W'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic set_registers(int unsigned left, int unsigned top, int unsigned bpl,
                                int unsigned limit);
      csr_write(CSR_LEFT_COL, left);
      csr_write(CSR_TOP_ROW, top);
      csr_write(CSR_BYTES_PER_LINE, bpl);
      csr_write(CSR_ROW_LIMIT, limit);
      settings_used++;
   endtask

   // Wait for all beats out and all pixels back, then let trailing bytes settle
   task automatic wait_drained();
      @(posedge clock);
      while (encoded_q.size() != 0 || req_bus.valid || expected_pixels_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      reset             = 1'b1;
      csr_wen           = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.func      = FUNC_DATA;
      req_bus.data_byte = '0;
      rsp_bus.ready     = 1'b0;
      cfg_left  = '0;
      cfg_top   = '0;
      cfg_bpl   = BPL_RESET;
      cfg_limit = ROW_LIMIT_RESET;
      pos_col   = '0;
      pos_row   = '0;
      run_armed = 1'b0;
      run_len   = '0;
      img_done  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: data before any restart, literal extremes, zero/one/full runs,
      // a marker value as run color, restart data ignored, restart dropping a run
      send_idle_pct = 28;
      recv_idle_pct = 66;
      queue_byte(FUNC_DATA, 8'h00);
      queue_byte(FUNC_DATA, 8'hBF);
      queue_byte(FUNC_DATA, 8'h55);
      queue_byte(FUNC_DATA, 8'hAA);
      queue_byte(FUNC_DATA, 8'h80);
      queue_run(6'd0, 8'h12);
      queue_run(6'd63, 8'hFF);
      queue_run(6'd1, 8'h00);
      queue_run(6'd3, 8'hC5);
      queue_byte(FUNC_BEGIN, 8'hFF);
      queue_byte(FUNC_DATA, 8'h7F);
      queue_byte(FUNC_DATA, 8'hC5);
      queue_byte(FUNC_BEGIN, 8'h00);
      queue_byte(FUNC_DATA, 8'h01);
      wait_drained();

      // Short lines and a low row limit so images finish often
      set_registers(100, 3, 5, 12);
      queue_byte(FUNC_BEGIN, 8'h00);
      queue_random_bytes(20);
      wait_drained();

      // Widest lines from the rightmost start: full runs push the column to saturation
      send_idle_pct = 66;
      recv_idle_pct = 28;
      set_registers(2047, 0, 2047, 1023);
      queue_byte(FUNC_BEGIN, 8'h00);
      for (int i = 0; i < 34; i++) queue_run(6'd63, BYTE_W'($urandom_range(0, 255)));
      queue_byte(FUNC_DATA, 8'h3C);
      queue_byte(FUNC_DATA, 8'h21);
      wait_drained();

      // Start row past a zero limit: everything is dropped
      set_registers(0, 1023, 2047, 0);
      queue_byte(FUNC_BEGIN, 8'h00);
      queue_byte(FUNC_DATA, 8'h44);
      queue_run(6'd5, 8'h66);
      wait_drained();

      // Zero line width near the bottom of the screen
      set_registers(7, 390, 0, 1023);
      queue_byte(FUNC_BEGIN, 8'h00);
      queue_random_bytes(20);
      wait_drained();

      // No idling; carry on from the previous position without a restart
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_registers(33, 20, 17, 40);
      queue_random_bytes(25);
      wait_drained();

      // Lower the limit and narrow the line while an image may be open
      csr_write(CSR_ROW_LIMIT, 25);
      csr_write(CSR_BYTES_PER_LINE, 1);
      settings_used++;
      queue_random_bytes(12);
      wait_drained();

      if (expected_pixels_q.size() != 0)
         report_mismatch("pixels left over", expected_pixels_q.size(), 0);
      $display("Decoded %0d beats into %0d checked pixels over %0d register settings",
               bytes_taken, pixels_seen, settings_used);
      $display("Covered literals, zero and full runs, restarts, line wrap, "
               , "column saturation and the row limit");
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
